// ===== sv/tlgr_pkg.sv =====
package tlgr_pkg;

  localparam int LINE_CHARS   = 21;
  localparam int PAGE_COLUMNS = 128;
  localparam int CELL_COLS    = 6;
  localparam int GLYPH_COLS   = 5;
  localparam int COL_W        = 7;
  localparam int CELL_W       = 5;
  localparam int GLYPH_IDX_W  = 6;
  localparam int PAGE_POS_W   = 9;

  typedef logic [GLYPH_IDX_W-1:0] glyph_idx_t;
  typedef logic [GLYPH_COLS-1:0][COL_W-1:0] glyph_t;

  // Font ROM layout: letters, then numerals, then punctuation.
  localparam glyph_idx_t GlyphAlpha   = 6'd0;
  localparam glyph_idx_t GlyphNumeral = 6'd26;
  localparam glyph_idx_t GlyphDash    = 6'd36;
  localparam glyph_idx_t GlyphDot     = 6'd37;
  localparam glyph_idx_t GlyphColon   = 6'd38;
  localparam glyph_idx_t GlyphSlash   = 6'd39;
  localparam glyph_idx_t GlyphPercent = 6'd40;
  localparam glyph_idx_t GlyphQuery   = 6'd41;
  localparam glyph_idx_t GlyphBlank   = 6'd42;

  function automatic glyph_idx_t glyph_index(logic [7:0] code);
    logic [7:0] up;
    glyph_idx_t idx;
    up = code;
    if (code >= 8'h61 && code <= 8'h7a) begin
      up = code - 8'd32;
    end
    priority if (up >= 8'h41 && up <= 8'h5a) begin
      idx = GlyphAlpha + 6'(up - 8'h41);
    end else if (up >= 8'h30 && up <= 8'h39) begin
      idx = GlyphNumeral + 6'(up - 8'h30);
    end else if (up == 8'h2d) begin
      idx = GlyphDash;
    end else if (up == 8'h2e) begin
      idx = GlyphDot;
    end else if (up == 8'h3a) begin
      idx = GlyphColon;
    end else if (up == 8'h2f) begin
      idx = GlyphSlash;
    end else if (up == 8'h25) begin
      idx = GlyphPercent;
    end else if (up == 8'h20) begin
      idx = GlyphBlank;
    end else begin
      idx = GlyphQuery;
    end
    return idx;
  endfunction

  function automatic glyph_t g5(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
                                logic [7:0] c3, logic [7:0] c4);
    return {c4[COL_W-1:0], c3[COL_W-1:0], c2[COL_W-1:0], c1[COL_W-1:0], c0[COL_W-1:0]};
  endfunction

  function automatic glyph_t font_rom(glyph_idx_t idx);
    glyph_t g;
    unique case (idx)
      6'd0:  g = g5(8'h7e, 8'h09, 8'h09, 8'h09, 8'h7e);
      6'd1:  g = g5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h36);
      6'd2:  g = g5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h22);
      6'd3:  g = g5(8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c);
      6'd4:  g = g5(8'h7f, 8'h49, 8'h49, 8'h49, 8'h41);
      6'd5:  g = g5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h01);
      6'd6:  g = g5(8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a);
      6'd7:  g = g5(8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f);
      6'd8:  g = g5(8'h41, 8'h41, 8'h7f, 8'h41, 8'h41);
      6'd9:  g = g5(8'h20, 8'h40, 8'h41, 8'h3f, 8'h01);
      6'd10: g = g5(8'h7f, 8'h08, 8'h14, 8'h22, 8'h41);
      6'd11: g = g5(8'h7f, 8'h40, 8'h40, 8'h40, 8'h40);
      6'd12: g = g5(8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f);
      6'd13: g = g5(8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f);
      6'd14: g = g5(8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e);
      6'd15: g = g5(8'h7f, 8'h09, 8'h09, 8'h09, 8'h06);
      6'd16: g = g5(8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e);
      6'd17: g = g5(8'h7f, 8'h09, 8'h19, 8'h29, 8'h46);
      6'd18: g = g5(8'h26, 8'h49, 8'h49, 8'h49, 8'h32);
      6'd19: g = g5(8'h01, 8'h01, 8'h7f, 8'h01, 8'h01);
      6'd20: g = g5(8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f);
      6'd21: g = g5(8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f);
      6'd22: g = g5(8'h3f, 8'h40, 8'h30, 8'h40, 8'h3f);
      6'd23: g = g5(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      6'd24: g = g5(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      6'd25: g = g5(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      6'd26: g = g5(8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e);
      6'd27: g = g5(8'h00, 8'h42, 8'h7f, 8'h40, 8'h00);
      6'd28: g = g5(8'h62, 8'h51, 8'h49, 8'h49, 8'h46);
      6'd29: g = g5(8'h22, 8'h41, 8'h49, 8'h49, 8'h36);
      6'd30: g = g5(8'h18, 8'h14, 8'h12, 8'h7f, 8'h10);
      6'd31: g = g5(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      6'd32: g = g5(8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30);
      6'd33: g = g5(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      6'd34: g = g5(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      6'd35: g = g5(8'h06, 8'h49, 8'h49, 8'h29, 8'h1e);
      6'd36: g = g5(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      6'd37: g = g5(8'h00, 8'h00, 8'h40, 8'h00, 8'h00);
      6'd38: g = g5(8'h00, 8'h00, 8'h24, 8'h00, 8'h00);
      6'd39: g = g5(8'h60, 8'h10, 8'h08, 8'h04, 8'h03);
      6'd40: g = g5(8'h63, 8'h13, 8'h08, 8'h64, 8'h63);
      6'd41: g = g5(8'h02, 8'h01, 8'h59, 8'h09, 8'h06);
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== sv/tlgr_if.sv =====
interface tlgr_char_if import tlgr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface tlgr_cell_if import tlgr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_index;
  logic [COL_W-1:0]  column0;
  logic [COL_W-1:0]  column1;
  logic [COL_W-1:0]  column2;
  logic [COL_W-1:0]  column3;
  logic [COL_W-1:0]  column4;
  logic [COL_W-1:0]  column5;
  logic              line_done;

  modport source (output valid, output cell_index, output column0, output column1,
                  output column2, output column3, output column4, output column5,
                  output line_done, input ready);
  modport sink (input valid, input cell_index, input column0, input column1,
                input column2, input column3, input column4, input column5,
                input line_done, output ready);
endinterface

// ===== sv/text_line_glyph_renderer.sv =====
// Character generator for one display page line, 5x7 font.
// char_i carries one character code per transfer; cell_o carries one 6-column
// cell per transfer (five glyph columns, a zero spacer column, the cell index).
// Lowercase shares the uppercase glyphs; unknown codes draw a question mark.
// Only the first LINE_CHARS characters are drawn; later nonzero codes are
// taken and dropped without a cell.
// A zero code ends the line: blank cells follow up to the last character cell,
// then a tail cell at index LINE_CHARS with line_done set, and the position
// returns to cell 0. While those cells are issued, char_i.ready stays low.
// A character transfer loads the font ROM read register; the output register
// loads from it when cell_o is free, and the cell is then offered on cell_o.
// Throughput: one character per cycle while cell_o does not stall; a zero code
// blocks input while its blank and tail cells are issued in turn, paced by the
// single font ROM read port.
// When cell_o stalls, the output register and the ROM read register hold and
// char_i.ready drops once both are full; nothing is lost.
// Reset clears the position, the end-of-line sequencer and both valid flags.
module text_line_glyph_renderer import tlgr_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  tlgr_char_if.sink   char_i,
  tlgr_cell_if.source cell_o
);

  logic [CELL_W-1:0] pos_q, pos_d;
  logic              fill_q, fill_d;

  logic              rd_valid_q;
  logic [CELL_W-1:0] rd_cell_q;
  logic              rd_last_q;
  glyph_t            rom_q;

  logic              out_valid_q;
  logic [CELL_W-1:0] out_cell_q;
  glyph_t            out_cols_q;
  logic              out_last_q;

  logic              out_load, rd_adv, in_fire, issue, pos_full;
  glyph_idx_t        issue_idx;
  glyph_t            clip_cols;
  logic [PAGE_POS_W-1:0] page_base;

  assign out_load = rd_valid_q && (!out_valid_q || cell_o.ready);
  assign rd_adv   = !rd_valid_q || out_load;
  assign char_i.ready = rd_adv && !fill_q;
  assign in_fire  = char_i.valid && char_i.ready;
  assign pos_full = (pos_q == CELL_W'(LINE_CHARS));

  always_comb begin
    issue     = 1'b0;
    issue_idx = GlyphBlank;
    pos_d     = pos_q;
    fill_d    = fill_q;
    if (fill_q) begin
      if (rd_adv) begin
        issue = 1'b1;
        if (pos_full) begin
          pos_d  = '0;
          fill_d = 1'b0;
        end else begin
          pos_d = pos_q + 1'b1;
        end
      end
    end else if (in_fire) begin
      if (char_i.char_code == 8'd0) begin
        fill_d = 1'b1;
      end else if (!pos_full) begin
        // drop characters past the end of the line
        issue     = 1'b1;
        issue_idx = glyph_index(char_i.char_code);
        pos_d     = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fill_q      <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      fill_q <= fill_d;
      if (rd_adv) begin
        rd_valid_q <= issue;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (cell_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Font ROM, registered read.
  always_ff @(posedge clk_i) begin
    if (rd_adv && issue) begin
      rom_q     <= font_rom(issue_idx);
      rd_cell_q <= pos_q;
      rd_last_q <= fill_q && pos_full;
    end
  end

  // Blank any column that falls off the right edge of the page.
  always_comb begin
    page_base = PAGE_POS_W'(CELL_COLS) * PAGE_POS_W'(rd_cell_q);
    for (int c = 0; c < GLYPH_COLS; c++) begin
      if (page_base + PAGE_POS_W'(c) >= PAGE_POS_W'(PAGE_COLUMNS)) begin
        clip_cols[c] = '0;
      end else begin
        clip_cols[c] = rom_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cell_q <= rd_cell_q;
      out_cols_q <= clip_cols;
      out_last_q <= rd_last_q;
    end
  end

  assign cell_o.valid      = out_valid_q;
  assign cell_o.cell_index = out_cell_q;
  assign cell_o.column0    = out_cols_q[0];
  assign cell_o.column1    = out_cols_q[1];
  assign cell_o.column2    = out_cols_q[2];
  assign cell_o.column3    = out_cols_q[3];
  assign cell_o.column4    = out_cols_q[4];
  assign cell_o.column5    = '0;
  assign cell_o.line_done  = out_last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= CELL_W'(LINE_CHARS))
    else $error("cell position beyond line");

  a_done_is_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.valid && cell_o.line_done |->
      cell_o.cell_index == CELL_W'(LINE_CHARS) && cell_o.column0 == '0 &&
      cell_o.column2 == '0 && cell_o.column4 == '0)
    else $error("tail cell not blank or misplaced");

  a_tail_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_o.valid && cell_o.cell_index == CELL_W'(LINE_CHARS) |-> cell_o.line_done)
    else $error("tail index without line_done");

  a_fill_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q |-> !char_i.ready)
    else $error("input taken during end-of-line fill");

  a_fill_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(fill_q) |-> pos_q == '0)
    else $error("position not reset after line end");

endmodule
